FILE: rtl/core/four_tap_gfsr_generator_unit_assert.svh
// Assertion macros for the four-tap GFSR generator.
// Included by the modules that carry concurrent assertions.
`ifndef FOUR_TAP_GFSR_GENERATOR_UNIT_ASSERT_SVH
`define FOUR_TAP_GFSR_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFSR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GFSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/gfsr_pkg.sv
// Shared constants, types and ring arithmetic for the four-tap GFSR generator.
// No dependencies.
`timescale 1ns / 1ps

package gfsr_pkg;

	localparam int RING_DEPTH = 521;
	localparam int WORD_BITS  = 32;
	localparam int ADDR_BITS  = $clog2(RING_DEPTH);
	localparam int BIT_BITS   = $clog2(WORD_BITS);
	localparam int TAP_A      = 86;
	localparam int TAP_B      = 197;
	localparam int TAP_C      = 447;
	localparam logic [31:0] LCG_MUL = 32'd1664525;

	// Command codes carried on the input stream.
	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// Memory write request from the seeding engine.
	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		word_t wr_data;
		logic  busy;
		logic  done;
	} seed_wr_t;

	// Position plus a tap offset, wrapped around the ring.
	function automatic addr_t ring_add(input addr_t base, input int off);
		logic [ADDR_BITS:0] sum;
		sum = {1'b0, base} + (ADDR_BITS+1)'(off);
		if (sum >= (ADDR_BITS+1)'(RING_DEPTH)) begin
			sum = sum - (ADDR_BITS+1)'(RING_DEPTH);
		end
		return sum[ADDR_BITS-1:0];
	endfunction

endpackage

FILE: rtl/core/four_tap_gfsr_generator_unit.sv
// Top level of the four-tap GFSR generator: draw sequencer and output register.
// Depends on gfsr_pkg, gfsr_wram, gfsr_seeder and the assertion macro header.
`timescale 1ns / 1ps
`include "four_tap_gfsr_generator_unit_assert.svh"

// Usage:
// The input stream carries one command per transfer: s_tuser selects the
// action (0 = seed, 1 = draw) and s_tdata carries the 32-bit seed.
// A seed produces no output. It runs an LCG fill of the 521-bit ring
// and then builds 521 words one bit per cycle; no command is accepted
// until the seed is done.
// A draw produces one output transfer: m_tdata[31:0] is the word and
// m_tdata[62:32] the word shifted right by one. A draw reads the word and
// its first tap, then its other two taps, through the two registered read
// ports of the word memory, then combines them; later passes write the word back.
// A finished result waits in the output register; the next command is
// accepted meanwhile, and a draw only stalls its final step while the
// receiver holds m_tready low on an occupied output register.
// Reset empties the output register and marks the generator unseeded; draws
// before the first seed return zero.
module four_tap_gfsr_generator_unit
	import gfsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // seed_value[31:0]
	input  logic        s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // random_word[31:0], random_upper31[62:32], zero[63]
);

	typedef enum logic [1:0] {ST_IDLE, ST_SEED, ST_RD2, ST_FIN} state_t;

	state_t   state_q;
	addr_t    pos_q;
	logic     first_pass_q;
	logic     seeded_q;
	word_t    self_q;
	word_t    acc_q;
	logic     out_valid_q;
	word_t    out_word_q;
	seed_wr_t sd_wr;
	logic     accept;
	logic     seed_start;
	logic     rd_en;
	addr_t    rd_addr_a;
	addr_t    rd_addr_b;
	word_t    rd_data_a;
	word_t    rd_data_b;
	logic     out_free;
	logic     fin_go;
	word_t    new_word;
	logic     mem_wr_en;
	addr_t    mem_wr_addr;
	word_t    mem_wr_data;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign seed_start = accept && (s_tuser == ACT_SEED);
	assign out_free   = !out_valid_q || m_tready;
	assign fin_go     = (state_q == ST_FIN) && out_free;

	// Read addresses: word and first tap, then the other two taps.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = pos_q;
		rd_addr_b = ring_add(pos_q, TAP_A);
		if (accept && (s_tuser != ACT_SEED)) begin
			rd_en = 1'b1;
		end else if (state_q == ST_RD2) begin
			rd_en     = 1'b1;
			rd_addr_a = ring_add(pos_q, TAP_B);
			rd_addr_b = ring_add(pos_q, TAP_C);
		end
	end

	// Later passes update the word in place from its taps.
	assign new_word = first_pass_q ? (acc_q ^ rd_data_a ^ rd_data_b) : self_q;

	// Write port shared between the seeding engine and draw write-back.
	always_comb begin
		mem_wr_en   = sd_wr.wr_en;
		mem_wr_addr = sd_wr.wr_addr;
		mem_wr_data = sd_wr.wr_data;
		if (fin_go && first_pass_q) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = pos_q;
			mem_wr_data = new_word;
		end
	end

	gfsr_wram u_wram (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	gfsr_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_start),
		.seed   (s_tdata),
		.wr     (sd_wr)
	);

	// Draw sequencer, ring position and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			first_pass_q <= 1'b0;
			seeded_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == ACT_SEED) ? ST_SEED : ST_RD2;
					end
				end
				ST_SEED: begin
					if (sd_wr.done) begin
						pos_q        <= '0;
						first_pass_q <= 1'b0;
						seeded_q     <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_RD2: begin
					self_q  <= rd_data_a;
					acc_q   <= rd_data_a ^ rd_data_b;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= seeded_q ? new_word : '0;
						if (pos_q == addr_t'(RING_DEPTH - 1)) begin
							pos_q        <= '0;
							first_pass_q <= 1'b1;
						end else begin
							pos_q <= pos_q + addr_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_word_q[WORD_BITS-1:1], out_word_q};

	`GFSR_ASSERT_NOW(a_pos_in_ring, clk, arst_n, 1'b1, pos_q <= addr_t'(RING_DEPTH - 1), "ring position out of range")
	`GFSR_ASSERT_NOW(a_no_accept_seeding, clk, arst_n, sd_wr.busy, !s_tready, "command accepted while seeding")
	`GFSR_ASSERT_NEXT(a_seed_resets_pos, clk, arst_n, sd_wr.done, pos_q == '0 && !first_pass_q, "seed did not rewind the ring")
	`GFSR_ASSERT_NOW(a_wb_only_late_pass, clk, arst_n, mem_wr_en && !sd_wr.busy, fin_go && first_pass_q, "stray word write-back")

endmodule

FILE: rtl/core/gfsr_wram.sv
// Word ring storage: one write port, two registered read ports.
// Depends on gfsr_pkg.
`timescale 1ns / 1ps

module gfsr_wram
	import gfsr_pkg::*;
(
	input  logic  clk,
	input  logic  wr_en,
	input  addr_t wr_addr,
	input  word_t wr_data,
	input  logic  rd_en,
	input  addr_t rd_addr_a,
	input  addr_t rd_addr_b,
	output word_t rd_data_a,
	output word_t rd_data_b
);

	word_t mem_q [RING_DEPTH];
	word_t rd_a_q;
	word_t rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read ports; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

FILE: rtl/core/gfsr_seeder.sv
// Seeding engine: LCG bit fill, then bitwise word build through a tapped shift ring.
// Depends on gfsr_pkg.
`timescale 1ns / 1ps

module gfsr_seeder
	import gfsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] seed,
	output seed_wr_t    wr
);

	typedef enum logic [1:0] {SD_IDLE, SD_LOAD, SD_BUILD} sd_state_t;

	sd_state_t              state_q;
	logic [31:0]            lcg_q;
	logic [RING_DEPTH-1:0]  ring_q;
	addr_t                  cnt_q;
	logic [BIT_BITS-1:0]    bit_q;
	word_t                  acc_q;
	logic                   wr_en_q;
	word_t                  wr_data_q;
	addr_t                  wr_addr_q;
	logic                   done_q;
	logic                   fb;
	logic [31:0]            prod;

	// Bit ring feedback from the fixed taps.
	assign fb   = ring_q[0] ^ ring_q[TAP_A] ^ ring_q[TAP_B] ^ ring_q[TAP_C];
	// Only the low 32 bits of the LCG product are kept.
	assign prod = lcg_q * LCG_MUL;

	// Sequencer, shift ring and write request registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			wr_en_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			done_q  <= 1'b0;
			unique case (state_q)
				SD_IDLE: begin
					if (start) begin
						lcg_q   <= seed;
						cnt_q   <= '0;
						state_q <= SD_LOAD;
					end
				end
				SD_LOAD: begin
					ring_q <= {lcg_q[31], ring_q[RING_DEPTH-1:1]};
					lcg_q  <= prod + 32'd1;
					if (cnt_q == addr_t'(RING_DEPTH - 1)) begin
						cnt_q   <= '0;
						bit_q   <= '0;
						state_q <= SD_BUILD;
					end else begin
						cnt_q <= cnt_q + addr_t'(1);
					end
				end
				SD_BUILD: begin
					ring_q <= {fb, ring_q[RING_DEPTH-1:1]};
					acc_q  <= {acc_q[WORD_BITS-2:0], ring_q[0]};
					bit_q  <= bit_q + BIT_BITS'(1);
					if (bit_q == BIT_BITS'(WORD_BITS - 1)) begin
						wr_en_q   <= 1'b1;
						wr_addr_q <= cnt_q;
						wr_data_q <= {acc_q[WORD_BITS-2:0], ring_q[0]};
						if (cnt_q == addr_t'(RING_DEPTH - 1)) begin
							done_q  <= 1'b1;
							state_q <= SD_IDLE;
						end else begin
							cnt_q <= cnt_q + addr_t'(1);
						end
					end
				end
				default: state_q <= SD_IDLE;
			endcase
		end
	end

	assign wr.wr_en   = wr_en_q;
	assign wr.wr_addr = wr_addr_q;
	assign wr.wr_data = wr_data_q;
	assign wr.busy    = (state_q != SD_IDLE) || wr_en_q;
	assign wr.done    = done_q;

endmodule

FILE: sim/tb_four_tap_gfsr_generator_unit.sv
// Self-checking testbench for the four-tap GFSR generator: seeds and draws go in on the
// input stream, and every drawn word is checked against a predictor kept in the bench.
// Depends on gfsr_pkg and the four_tap_gfsr_generator_unit RTL.
`timescale 1ns / 1ps

module tb_four_tap_gfsr_generator_unit;
	import gfsr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic        action;
		logic [31:0] seed;
		logic        wait_idle;  // Hold this command until all words have arrived.
	} command_t;

	typedef struct {
		logic [31:0] word;
		logic [30:0] upper31;
	} draw_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	command_t     pending_cmds[$];
	draw_result_t expected_words[$];
	command_t     shown_cmd;
	bit           stimulus_done = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	// Predictor state: word ring, seeding bit ring, read position, first-pass flag.
	logic [31:0] gen_words[RING_DEPTH];
	logic        gen_bits[RING_DEPTH];
	int          gen_pos = 0;
	bit          gen_wrapped = 0;

	four_tap_gfsr_generator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic int wrap_index(input int base, input int off);
		return (base + off) % RING_DEPTH;
	endfunction

	// Fill the bit ring from the LCG top bits, then build each word MSB first.
	function automatic void reseed_generator(input logic [31:0] s);
		int k;
		logic [31:0] w;
		k = 0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			gen_bits[i] = s[31];
			s = s * LCG_MUL + 32'd1;
		end
		for (int i = 0; i < RING_DEPTH; i++) begin
			w = '0;
			for (int b = 0; b < WORD_BITS; b++) begin
				w = {w[30:0], gen_bits[k]};
				gen_bits[k] ^= gen_bits[wrap_index(k, TAP_A)] ^ gen_bits[wrap_index(k, TAP_B)]
					^ gen_bits[wrap_index(k, TAP_C)];
				k = wrap_index(k, 1);
			end
			gen_words[i] = w;
		end
		gen_pos = 0;
		gen_wrapped = 0;
	endfunction

	// Later passes update the word in place from its three taps before returning it.
	function automatic logic [31:0] draw_generator();
		logic [31:0] w;
		if (gen_wrapped) begin
			gen_words[gen_pos] ^= gen_words[wrap_index(gen_pos, TAP_A)]
				^ gen_words[wrap_index(gen_pos, TAP_B)] ^ gen_words[wrap_index(gen_pos, TAP_C)];
		end
		w = gen_words[gen_pos];
		gen_pos++;
		if (gen_pos >= RING_DEPTH) begin
			gen_pos = 0;
			gen_wrapped = 1;
		end
		return w;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			gen_words[i] = '0;
			gen_bits[i] = 1'b0;
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				if (shown_cmd.action == ACT_SEED) begin
					reseed_generator(shown_cmd.seed);
				end else begin
					logic [31:0] w;
					w = draw_generator();
					expected_words.push_back('{word: w, upper31: w[31:1]});
				end
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].wait_idle && expected_words.size() > 0)) begin
					shown_cmd = pending_cmds.pop_front();
					s_tdata <= shown_cmd.seed;
					s_tuser <= shown_cmd.action;
					next_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40, 0);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					end
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// Receiver: stall mode steps with the cycle count through always ready, half ready, mostly stalled and mostly ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case ((cycle_count / 256) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(1, 0);
				2: m_tready <= ($urandom_range(3, 0) == 0);
				default: m_tready <= ($urandom_range(7, 0) != 0);
			endcase
		end
	end

	// Check each output transfer against the oldest predicted word.
	always @(posedge clk) begin
		draw_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected output transfer: m_tdata=%h", m_tdata);
				end
			end else begin
				exp_res = expected_words.pop_front();
				if (m_tdata[31:0] !== exp_res.word || m_tdata[62:32] !== exp_res.upper31
						|| m_tdata[63] !== 1'b0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display({"word mismatch: expected word=%h upper31=%h, ",
							"got word=%h upper31=%h top=%b"},
							exp_res.word, exp_res.upper31,
							m_tdata[31:0], m_tdata[62:32], m_tdata[63]);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("four_tap_gfsr_generator_unit regression: fail");
			$finish;
		end
	end

	task automatic add_cmd(input logic act, input logic [31:0] s, input logic hold);
		pending_cmds.push_back('{action: act, seed: s, wait_idle: hold});
	endtask

	initial begin
		int mid_seed;
		// Draws before any seed return zero; then seeds at both extremes.
		for (int i = 0; i < 3; i++) add_cmd(ACT_DRAW, $urandom, 1'b0);
		add_cmd(ACT_SEED, 32'h0000_0000, 1'b0);
		for (int i = 0; i < 5; i++) add_cmd(ACT_DRAW, '0, 1'b0);
		add_cmd(ACT_SEED, 32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < 5; i++) add_cmd(ACT_DRAW, 32'hFFFF_FFFF, 1'b0);
		add_cmd(ACT_SEED, 32'h8000_0001, 1'b0);
		for (int i = 0; i < 4; i++) add_cmd(ACT_DRAW, $urandom, 1'b0);

		// First random run crosses into the in-place update pass.
		add_cmd(ACT_SEED, $urandom, 1'b1);
		for (int i = 0; i < 560; i++) add_cmd(ACT_DRAW, $urandom, $urandom_range(99, 0) == 0);

		// Second run, with one seed landing somewhere in the middle of it.
		mid_seed = $urandom_range(400, 100);
		add_cmd(ACT_SEED, $urandom, 1'b0);
		for (int i = 0; i < 570; i++) begin
			if (i == mid_seed) add_cmd(ACT_SEED, $urandom, 1'b0);
			add_cmd(ACT_DRAW, $urandom, $urandom_range(99, 0) == 0);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && expected_words.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("four_tap_gfsr_generator_unit regression: pass");
		end else begin
			$display("four_tap_gfsr_generator_unit regression: fail");
		end
		$finish;
	end

endmodule
